// ===== rtl/htw_pkg.sv =====
// ----------------------------------------------------------------------------
// Hashed timer wheel package
// Shared constants, command and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package htw_pkg;

   // default geometry
   localparam int NUM_SLOTS_DEF  = 64;
   localparam int MAX_TIMERS_DEF = 32;

   // fixed field widths
   localparam int KIND_W     = 2;
   localparam int TIMEOUT_W  = 32;
   localparam int HANDLE_W   = 5;
   localparam int STATUS_W   = 2;
   localparam int INTERVAL_W = 16;

   // a non-negative timeout, and so the tick count, fits in this many bits
   localparam int TICK_W = TIMEOUT_W - 1;

   // command codes
   localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NEG_TIME   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_POOL_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_ACTIVE = 2'd3;

   // sequencer states
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_DIV1  = 6'b000010,
      ST_DIV2  = 6'b000100,
      ST_PLACE = 6'b001000,
      ST_SCAN  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

endpackage

// ===== rtl/hashed_timer_wheel.sv =====
// ----------------------------------------------------------------------------
// Hashed timer wheel
// Timer pool on a wheel of NUM_SLOTS slots; add, delete and tick commands.
// ----------------------------------------------------------------------------
//
//   channel  ports                 handshake
//   -------  --------------------  ----------------------------------------
//   request  req_kind/timeout/     taken on start && !busy
//            req_handle
//   result   rsp_status/handle_out one-cycle strobe rsp_valid, no back-pressure
//            /expired/last
//   csr      csr_slot_interval     written on csr_valid && csr_ready
//
// Add: busy through 31 restoring steps for timeout / interval, the split of
// ticks by NUM_SLOTS (reciprocal multiply, remainder, correction) and the
// store of the entry. Rejected adds, deletes, unknown commands: answered next cycle.
// Tick: busy through a scan of all entries, one entry read per cycle (one read
// and one write port), at most one result word per cycle. Reset clears valid
// flags and slot, sets interval to one, no clearing pass; results cannot be stalled.
// ----------------------------------------------------------------------------
module hashed_timer_wheel #(
   parameter int NUM_SLOTS  = htw_pkg::NUM_SLOTS_DEF,
   parameter int MAX_TIMERS = htw_pkg::MAX_TIMERS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request
   input  logic                                  start,
   output logic                                  busy,
   input  logic [htw_pkg::KIND_W-1:0]            req_kind,
   input  logic signed [htw_pkg::TIMEOUT_W-1:0]  req_timeout,
   input  logic [htw_pkg::HANDLE_W-1:0]          req_handle,
   // result
   output logic                                  rsp_valid,
   output logic [htw_pkg::STATUS_W-1:0]          rsp_status,
   output logic [htw_pkg::HANDLE_W-1:0]          rsp_handle_out,
   output logic                                  rsp_expired,
   output logic                                  rsp_last,
   // configuration
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [htw_pkg::INTERVAL_W-1:0]        csr_slot_interval
);
   import htw_pkg::*;

   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam int IDX_W  = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
   localparam int ROT_W  = TICK_W - 1;
   localparam int ENT_W  = SLOT_W + ROT_W;
   localparam int CNT_W  = $clog2(TICK_W);

   localparam logic [CNT_W-1:0]      DIV_LAST    = CNT_W'(TICK_W - 1);
   localparam logic [IDX_W-1:0]      IDX_LAST    = IDX_W'(MAX_TIMERS - 1);
   localparam logic [INTERVAL_W-1:0] SLOTS_DIV   = INTERVAL_W'(NUM_SLOTS);
   localparam logic [SLOT_W:0]       SLOTS_EXT   = (SLOT_W + 1)'(NUM_SLOTS);
   localparam logic [SLOT_W-1:0]     SLOT_TOP    = SLOT_W'(NUM_SLOTS - 1);
   localparam logic [TICK_W-1:0]     SLOTS_TICK  = TICK_W'(NUM_SLOTS);
   localparam logic [31:0]           SLOTS_RECIP = 32'((64'd1 << 32) / NUM_SLOTS);

   // control state
   state_type               state_ff, state_in;
   logic [SLOT_W-1:0]       cur_slot_ff, cur_slot_in;
   logic [MAX_TIMERS-1:0]   valid_ff, valid_in;
   logic [INTERVAL_W-1:0]   interval_ff, interval_in;
   logic [CNT_W-1:0]        div_cnt_ff, div_cnt_in;
   logic [IDX_W-1:0]        scan_idx_ff, scan_idx_in;
   logic                    proc_vld_ff, proc_vld_in;
   logic                    hold_vld_ff, hold_vld_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // payload
   logic [INTERVAL_W-1:0]   div_rem_ff, div_rem_in;
   logic [TICK_W-1:0]       div_quo_ff, div_quo_in;
   logic [ROT_W-1:0]        rot_est_ff, rot_est_in;
   logic [IDX_W-1:0]        free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]        proc_idx_ff, proc_idx_in;
   logic [IDX_W-1:0]        hold_idx_ff, hold_idx_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0]     rsp_handle_ff, rsp_handle_in;
   logic                    rsp_expired_ff, rsp_expired_in;
   logic                    rsp_last_ff, rsp_last_in;

   // entry memory: {slot, rotation}
   logic [ENT_W-1:0]        mem [MAX_TIMERS];
   logic [ENT_W-1:0]        mem_rdata_ff;
   logic                    mem_we;
   logic [IDX_W-1:0]        mem_waddr;
   logic [ENT_W-1:0]        mem_wdata;
   logic [IDX_W-1:0]        mem_raddr;

   // divider datapath
   logic [INTERVAL_W-1:0]   divisor;
   logic [INTERVAL_W:0]     rem_sh;
   logic                    quo_bit;
   logic [INTERVAL_W-1:0]   rem_nx;
   logic [TICK_W-1:0]       quo_nx;

   // split of the tick count by NUM_SLOTS
   logic [ROT_W+31:0]       recip_prod;
   logic [TICK_W-1:0]       split_rem;

   // free handle search
   logic                    free_found;
   logic [IDX_W-1:0]        free_idx;

   // scan view of the entry just read
   logic [SLOT_W-1:0]       rd_slot;
   logic [ROT_W-1:0]        rd_rot;
   logic [SLOT_W:0]         slot_sum;
   logic [SLOT_W-1:0]       new_slot;

   assign busy           = (state_ff != ST_IDLE);
   assign csr_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_handle_out = rsp_handle_ff;
   assign rsp_expired    = rsp_expired_ff;
   assign rsp_last       = rsp_last_ff;

   assign rd_slot = mem_rdata_ff[ENT_W-1:ROT_W];
   assign rd_rot  = mem_rdata_ff[ROT_W-1:0];

   // estimate ticks / NUM_SLOTS by reciprocal; low by at most one
   assign recip_prod = {{(ROT_W + 1){1'b0}}, div_quo_ff} * {{ROT_W{1'b0}}, SLOTS_RECIP};
   // remainder against the estimate, below twice NUM_SLOTS
   assign split_rem  = div_quo_ff - {1'b0, rot_est_ff} * SLOTS_TICK;

   // pick the lowest free handle
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   // one restoring division step; a zero interval divides as one
   always_comb begin
      divisor = (interval_ff == '0) ? INTERVAL_W'(1) : interval_ff;
      rem_sh  = {div_rem_ff, div_quo_ff[TICK_W-1]};
      quo_bit = (rem_sh >= {1'b0, divisor});
      if (quo_bit) begin
         rem_nx = INTERVAL_W'(rem_sh - {1'b0, divisor});
      end else begin
         rem_nx = rem_sh[INTERVAL_W-1:0];
      end
      quo_nx = {div_quo_ff[TICK_W-2:0], quo_bit};
   end

   // slot of a new timer: current slot plus offset, wrapped once
   always_comb begin
      slot_sum = {1'b0, cur_slot_ff} + {1'b0, div_rem_ff[SLOT_W-1:0]};
      if (slot_sum >= SLOTS_EXT) begin
         new_slot = SLOT_W'(slot_sum - SLOTS_EXT);
      end else begin
         new_slot = slot_sum[SLOT_W-1:0];
      end
   end

   // sequencer and next-state logic
   always_comb begin
      state_in       = state_ff;
      cur_slot_in    = cur_slot_ff;
      valid_in       = valid_ff;
      interval_in    = interval_ff;
      div_cnt_in     = div_cnt_ff;
      div_rem_in     = div_rem_ff;
      div_quo_in     = div_quo_ff;
      rot_est_in     = rot_est_ff;
      free_idx_in    = free_idx_ff;
      scan_idx_in    = scan_idx_ff;
      proc_vld_in    = 1'b0;
      proc_idx_in    = scan_idx_ff;
      hold_vld_in    = hold_vld_ff;
      hold_idx_in    = hold_idx_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = STAT_OK;
      rsp_handle_in  = '0;
      rsp_expired_in = 1'b0;
      rsp_last_in    = 1'b1;
      mem_we         = 1'b0;
      mem_waddr      = proc_idx_ff;
      mem_wdata      = {rd_slot, rd_rot - ROT_W'(1)};
      mem_raddr      = scan_idx_ff;

      // take a configuration word
      if (csr_valid && csr_ready) begin
         interval_in = csr_slot_interval;
      end

      // age or expire the entry read last cycle
      if (proc_vld_ff && valid_ff[proc_idx_ff] && (rd_slot == cur_slot_ff)) begin
         if (rd_rot != '0) begin
            mem_we = 1'b1;
         end else begin
            valid_in[proc_idx_ff] = 1'b0;
            hold_vld_in           = 1'b1;
            hold_idx_in           = proc_idx_ff;
            // release the previous expiry, not the final one
            if (hold_vld_ff) begin
               rsp_valid_in   = 1'b1;
               rsp_handle_in  = HANDLE_W'(hold_idx_ff);
               rsp_expired_in = 1'b1;
               rsp_last_in    = 1'b0;
            end
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_kind)
                  KIND_ADD: begin
                     if (req_timeout[TIMEOUT_W-1]) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_NEG_TIME;
                     end else if (!free_found) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_POOL_FULL;
                     end else begin
                        free_idx_in = free_idx;
                        div_quo_in  = req_timeout[TICK_W-1:0];
                        div_rem_in  = '0;
                        div_cnt_in  = '0;
                        state_in    = ST_DIV1;
                     end
                  end
                  KIND_DELETE: begin
                     rsp_valid_in  = 1'b1;
                     rsp_handle_in = req_handle;
                     if ((32'(req_handle) < MAX_TIMERS) &&
                         valid_ff[IDX_W'(req_handle)]) begin
                        valid_in[IDX_W'(req_handle)] = 1'b0;
                        rsp_status_in                = STAT_OK;
                     end else begin
                        rsp_status_in = STAT_NOT_ACTIVE;
                     end
                  end
                  KIND_TICK: begin
                     scan_idx_in = '0;
                     hold_vld_in = 1'b0;
                     state_in    = ST_SCAN;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         // timeout / interval; a zero quotient becomes one tick
         ST_DIV1: begin
            div_rem_in = rem_nx;
            div_quo_in = quo_nx;
            div_cnt_in = div_cnt_ff + CNT_W'(1);
            if (div_cnt_ff == DIV_LAST) begin
               div_quo_in = (quo_nx == '0) ? TICK_W'(1) : quo_nx;
               div_rem_in = '0;
               div_cnt_in = '0;
               state_in   = ST_DIV2;
            end
         end

         // ticks / NUM_SLOTS: estimate, take the remainder, correct by one
         ST_DIV2: begin
            div_cnt_in = div_cnt_ff + CNT_W'(1);
            if (div_cnt_ff == '0) begin
               rot_est_in = recip_prod[ROT_W+31:32];
            end else if (div_cnt_ff == CNT_W'(1)) begin
               div_quo_in = {1'b0, rot_est_ff};
               div_rem_in = INTERVAL_W'(split_rem);
            end else begin
               if (div_rem_ff >= SLOTS_DIV) begin
                  div_quo_in = div_quo_ff + TICK_W'(1);
                  div_rem_in = div_rem_ff - SLOTS_DIV;
               end
               div_cnt_in = '0;
               state_in   = ST_PLACE;
            end
         end

         // store the new timer and report its handle
         ST_PLACE: begin
            mem_we                = 1'b1;
            mem_waddr             = free_idx_ff;
            mem_wdata             = {new_slot, div_quo_ff[ROT_W-1:0]};
            valid_in[free_idx_ff] = 1'b1;
            rsp_valid_in          = 1'b1;
            rsp_handle_in         = HANDLE_W'(free_idx_ff);
            state_in              = ST_IDLE;
         end

         // issue one entry read per cycle
         ST_SCAN: begin
            proc_vld_in = 1'b1;
            proc_idx_in = scan_idx_ff;
            scan_idx_in = scan_idx_ff + IDX_W'(1);
            if (scan_idx_ff == IDX_LAST) begin
               scan_idx_in = '0;
               state_in    = ST_DONE;
            end
         end

         // last entry processed above; close the tick and advance the wheel
         ST_DONE: begin
            if (!proc_vld_ff) begin
               rsp_valid_in = 1'b1;
               if (hold_vld_ff) begin
                  rsp_handle_in  = HANDLE_W'(hold_idx_ff);
                  rsp_expired_in = 1'b1;
               end
               hold_vld_in = 1'b0;
               cur_slot_in = (cur_slot_ff == SLOT_TOP) ? '0
                                                       : cur_slot_ff + SLOT_W'(1);
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_slot_ff  <= '0;
         valid_ff     <= '0;
         interval_ff  <= INTERVAL_W'(1);
         div_cnt_ff   <= '0;
         scan_idx_ff  <= '0;
         proc_vld_ff  <= 1'b0;
         hold_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_slot_ff  <= cur_slot_in;
         valid_ff     <= valid_in;
         interval_ff  <= interval_in;
         div_cnt_ff   <= div_cnt_in;
         scan_idx_ff  <= scan_idx_in;
         proc_vld_ff  <= proc_vld_in;
         hold_vld_ff  <= hold_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      div_rem_ff     <= div_rem_in;
      div_quo_ff     <= div_quo_in;
      rot_est_ff     <= rot_est_in;
      free_idx_ff    <= free_idx_in;
      proc_idx_ff    <= proc_idx_in;
      hold_idx_ff    <= hold_idx_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_expired_ff <= rsp_expired_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // entry memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_raddr];
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Hashed timer wheel testbench
// Drives add, delete, tick and unknown commands through the start/busy port, with
// slot interval writes between phases, and checks every result word against
// a cycle-free model of the timer pool kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import htw_pkg::*;

   localparam int NUM_SLOTS  = NUM_SLOTS_DEF;
   localparam int MAX_TIMERS = MAX_TIMERS_DEF;

   // the one command code the package leaves out
   localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] handle;
      logic                expired;
      logic                last;
   } wheel_word_type;

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [TIMEOUT_W-1:0] timeout;
      logic [HANDLE_W-1:0]  handle;
      logic                 pinned;
      wheel_word_type       word;
   } cmd_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [KIND_W-1:0]     req_kind = KIND_TICK;
   logic [TIMEOUT_W-1:0]  req_timeout = '0;
   logic [HANDLE_W-1:0]   req_handle = '0;
   logic                  rsp_valid;
   logic [STATUS_W-1:0]   rsp_status;
   logic [HANDLE_W-1:0]   rsp_handle_out;
   logic                  rsp_expired;
   logic                  rsp_last;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [INTERVAL_W-1:0] csr_slot_interval = '0;

   // travels with each command: a word typed into the table replaces the
   // predicted one
   logic                  req_pinned = 1'b0;
   wheel_word_type        req_pin_word = '0;

   // bench copy of the wheel
   logic                  timer_live [MAX_TIMERS];
   logic [5:0]            timer_slot [MAX_TIMERS];
   logic [31:0]           timer_laps [MAX_TIMERS];
   logic [5:0]            wheel_pos;
   logic [INTERVAL_W-1:0] tick_interval;

   wheel_word_type        pending_words [$];
   cmd_row_type           directed_rows [14];

   int                    errors;
   int                    n_cmds;
   int                    n_words;
   int                    n_expiries;
   int                    n_writes;

   hashed_timer_wheel #(
      .NUM_SLOTS  (NUM_SLOTS),
      .MAX_TIMERS (MAX_TIMERS)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_timeout       (req_timeout),
      .req_handle        (req_handle),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_handle_out    (rsp_handle_out),
      .rsp_expired       (rsp_expired),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_slot_interval (csr_slot_interval)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Work out the words one command produces and queue them
   function automatic void predict_wheel(input logic [KIND_W-1:0] kind,
                                         input logic [TIMEOUT_W-1:0] tmo,
                                         input logic [HANDLE_W-1:0] hnd,
                                         input logic pinned,
                                         input wheel_word_type pin_word);
      wheel_word_type words [$];
      logic [31:0] si;
      logic [31:0] ticks;
      int          free_h;
      free_h = -1;
      case (kind)
         KIND_ADD: begin
            for (int i = MAX_TIMERS - 1; i >= 0; i--)
               if (!timer_live[i]) free_h = i;
            if (tmo[TIMEOUT_W-1]) begin
               words.push_back({STAT_NEG_TIME, 5'd0, 1'b0, 1'b1});
            end else if (free_h < 0) begin
               words.push_back({STAT_POOL_FULL, 5'd0, 1'b0, 1'b1});
            end else begin
               si = (tick_interval == '0) ? 32'd1 : 32'(tick_interval);
               ticks = tmo / si;
               if (ticks == 0) ticks = 1;
               timer_live[free_h] = 1'b1;
               timer_slot[free_h] = wheel_pos + ticks[5:0];
               timer_laps[free_h] = ticks / NUM_SLOTS;
               words.push_back({STAT_OK, 5'(free_h), 1'b0, 1'b1});
            end
         end
         KIND_DELETE: begin
            if (!timer_live[hnd]) begin
               words.push_back({STAT_NOT_ACTIVE, hnd, 1'b0, 1'b1});
            end else begin
               timer_live[hnd] = 1'b0;
               words.push_back({STAT_OK, hnd, 1'b0, 1'b1});
            end
         end
         KIND_TICK: begin
            // scan the current slot in handle order
            for (int i = 0; i < MAX_TIMERS; i++) begin
               if (timer_live[i] && timer_slot[i] == wheel_pos) begin
                  if (timer_laps[i] != 0) begin
                     timer_laps[i] = timer_laps[i] - 1;
                  end else begin
                     timer_live[i] = 1'b0;
                     words.push_back({STAT_OK, 5'(i), 1'b1, 1'b0});
                  end
               end
            end
            wheel_pos = wheel_pos + 6'd1;
            if (words.size() == 0)
               words.push_back({STAT_OK, 5'd0, 1'b0, 1'b1});
            else
               words[words.size() - 1].last = 1'b1;
         end
         default: begin
            words.push_back({STAT_OK, 5'd0, 1'b0, 1'b1});
         end
      endcase
      if (pinned) begin
         words.delete();
         words.push_back(pin_word);
      end
      foreach (words[i]) pending_words.push_back(words[i]);
   endfunction

   // Check result words, track interval writes and predict each command taken
   always @(posedge clock) begin
      wheel_word_type want;
      wheel_word_type got;
      if (reset) begin
         foreach (timer_live[i]) timer_live[i] = 1'b0;
         wheel_pos = '0;
         tick_interval = 16'd1;
      end else begin
         if (rsp_valid === 1'b1) begin
            got = {rsp_status, rsp_handle_out, rsp_expired, rsp_last};
            n_words++;
            if (rsp_expired === 1'b1) n_expiries++;
            if (pending_words.size() == 0) begin
               $display("%0t: unexpected result word status %0d handle %0d exp %0b last %0b",
                        $time, got.status, got.handle, got.expired, got.last);
               errors++;
            end else begin
               want = pending_words.pop_front();
               if (got !== want) begin
                  $display("%0t: result mismatch, expected status %0d handle %0d exp %0b last %0b",
                           $time, want.status, want.handle, want.expired, want.last);
                  $display("%0t:                  actual status %0d handle %0d exp %0b last %0b",
                           $time, got.status, got.handle, got.expired, got.last);
                  errors++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            tick_interval = csr_slot_interval;
            n_writes++;
         end
         if (start && !busy) begin
            n_cmds++;
            predict_wheel(req_kind, req_timeout, req_handle, req_pinned, req_pin_word);
         end
      end
   end

   function automatic cmd_row_type make_row(input logic [KIND_W-1:0] kind,
                                            input logic [TIMEOUT_W-1:0] tmo,
                                            input logic [HANDLE_W-1:0] hnd,
                                            input logic pinned,
                                            input logic [STATUS_W-1:0] st,
                                            input logic [HANDLE_W-1:0] hout);
      make_row = {kind, tmo, hnd, pinned, st, hout, 1'b0, 1'b1};
   endfunction

   // Hold start low for the gap, then offer the word until it is taken
   task automatic send_cmd(input cmd_row_type c, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_kind     <= c.kind;
      req_timeout  <= c.timeout;
      req_handle   <= c.handle;
      req_pinned   <= c.pinned;
      req_pin_word <= c.word;
      do @(posedge clock); while (busy);
   endtask

   // Drop start and wait until every expected word is in and the block is idle
   task automatic wait_drained();
      start <= 1'b0;
      do @(negedge clock); while (pending_words.size() != 0 || busy);
      @(posedge clock);
   endtask

   task automatic write_interval(input logic [INTERVAL_W-1:0] v);
      wait_drained();
      csr_valid         <= 1'b1;
      csr_slot_interval <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic int pick_gap(input bit quiet);
      if (quiet || $urandom_range(0, 2) != 0) return 0;
      return $urandom_range(1, 17);
   endfunction

   // Mostly timeouts that land a few laps out at most, some of any value
   function automatic logic [TIMEOUT_W-1:0] pick_timeout(input logic [INTERVAL_W-1:0] iv);
      int unsigned si;
      int unsigned r;
      si = (iv == '0) ? 1 : iv;
      r = $urandom_range(0, 99);
      if (r < 10) return $urandom;
      if (r < 18) return $urandom_range(0, si - 1);
      if (r < 75) return $urandom_range(0, 24) * si + $urandom_range(0, si - 1);
      return $urandom_range(0, 140) * si + $urandom_range(0, si - 1);
   endfunction

   task automatic send_random(input int count, input logic [INTERVAL_W-1:0] iv,
                              input bit quiet);
      int unsigned      r;
      logic [KIND_W-1:0] k;
      logic [HANDLE_W-1:0] h;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 38)      k = KIND_ADD;
         else if (r < 58) k = KIND_DELETE;
         else if (r < 95) k = KIND_TICK;
         else             k = KIND_UNKNOWN;
         // low handles are the ones most likely in use
         h = ($urandom_range(0, 9) < 7) ? HANDLE_W'($urandom_range(0, 7))
                                        : HANDLE_W'($urandom_range(0, 31));
         send_cmd(make_row(k, (k == KIND_ADD) ? pick_timeout(iv) : $urandom, h, 1'b0,
                           STAT_OK, 5'd0), pick_gap(quiet));
         if (n == count / 2 && !quiet) wait_drained();
      end
   endtask

   logic [INTERVAL_W-1:0] phase_iv;

   initial begin
      errors = 0; n_cmds = 0; n_words = 0; n_expiries = 0; n_writes = 0;

      // reset values first, then the extremes of every field
      directed_rows[0]  = make_row(KIND_TICK, 32'd0, 5'd0, 1'b1, STAT_OK, 5'd0);
      directed_rows[1]  = make_row(KIND_DELETE, 32'd0, 5'd0, 1'b1, STAT_NOT_ACTIVE, 5'd0);
      directed_rows[2]  = make_row(KIND_DELETE, 32'hFFFF_FFFF, 5'd31, 1'b1,
                                   STAT_NOT_ACTIVE, 5'd31);
      directed_rows[3]  = make_row(KIND_ADD, 32'hFFFF_FFFF, 5'd31, 1'b1, STAT_NEG_TIME, 5'd0);
      directed_rows[4]  = make_row(KIND_ADD, 32'h8000_0000, 5'd0, 1'b1, STAT_NEG_TIME, 5'd0);
      directed_rows[5]  = make_row(KIND_ADD, 32'd0, 5'd0, 1'b1, STAT_OK, 5'd0);
      directed_rows[6]  = make_row(KIND_ADD, 32'h7FFF_FFFF, 5'd0, 1'b1, STAT_OK, 5'd1);
      directed_rows[7]  = make_row(KIND_ADD, 32'd64, 5'd0, 1'b1, STAT_OK, 5'd2);
      directed_rows[8]  = make_row(KIND_ADD, 32'd63, 5'd0, 1'b1, STAT_OK, 5'd3);
      directed_rows[9]  = make_row(KIND_UNKNOWN, 32'hFFFF_FFFF, 5'd31, 1'b1, STAT_OK, 5'd0);
      // a lap counted down, then a plain expiry
      directed_rows[10] = make_row(KIND_TICK, 32'd0, 5'd0, 1'b0, STAT_OK, 5'd0);
      directed_rows[11] = make_row(KIND_TICK, 32'd0, 5'd0, 1'b0, STAT_OK, 5'd0);
      directed_rows[12] = make_row(KIND_DELETE, 32'd0, 5'd1, 1'b1, STAT_OK, 5'd1);
      directed_rows[13] = make_row(KIND_DELETE, 32'd0, 5'd1, 1'b1, STAT_NOT_ACTIVE, 5'd1);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_cmd(directed_rows[i], pick_gap(1'b0));

      // phase at the reset interval
      send_random(38, 16'd1, 1'b0);

      // zero interval, and a full pool that all expires on one tick
      write_interval(16'd0);
      for (int h = 0; h < MAX_TIMERS; h++)
         send_cmd(make_row(KIND_DELETE, $urandom, 5'(h), 1'b0, STAT_OK, 5'd0),
                  pick_gap(1'b0));
      for (int h = 0; h < MAX_TIMERS; h++)
         send_cmd(make_row(KIND_ADD, $urandom_range(0, 1), HANDLE_W'($urandom), 1'b0,
                           STAT_OK, 5'd0), pick_gap(1'b0));
      send_cmd(make_row(KIND_ADD, 32'd0, 5'd0, 1'b1, STAT_POOL_FULL, 5'd0), pick_gap(1'b0));
      repeat (2) send_cmd(make_row(KIND_TICK, $urandom, HANDLE_W'($urandom), 1'b0,
                                   STAT_OK, 5'd0), pick_gap(1'b0));
      send_random(38, 16'd0, 1'b0);

      write_interval(16'hFFFF);
      send_random(38, 16'hFFFF, 1'b0);

      write_interval(16'd5);
      send_random(38, 16'd5, 1'b0);

      // last phase back to back
      phase_iv = INTERVAL_W'($urandom_range(1, 65535));
      write_interval(phase_iv);
      send_random(38, phase_iv, 1'b1);

      wait_drained();
      repeat (70) @(posedge clock);

      $display("Covered %0d commands over %0d interval writes, zero and full scale included.",
               n_cmds, n_writes);
      $display("Checked %0d result words, %0d of them expiries.", n_words, n_expiries);
      if (errors == 0 && pending_words.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("%0d mismatches, %0d words never arrived", errors, pending_words.size());
         $display("tb_top failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #(20_000_000);
      $display("watchdog expired with %0d words outstanding", pending_words.size());
      $display("tb_top failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/htw_pkg.sv
rtl/hashed_timer_wheel.sv
tb/sv/tb_top.sv
